@@ hdl/ptrs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task scheduler package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ptrs_pkg;

	localparam int MAX_TASKS_DEF = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int TIME_W        = 8;
	localparam int IDX_W         = 3;
	localparam int NRES_W        = 4;

	localparam logic [TIME_W-1:0] HYPER_RESET = 8'd255;

	// Request actions.
	localparam logic [1:0] ACT_REGISTER = 2'd0;
	localparam logic [1:0] ACT_TICK     = 2'd1;
	localparam logic [1:0] ACT_DISPATCH = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_STATUS   = 2'd0;
	localparam logic [1:0] KIND_TASK     = 2'd1;
	localparam logic [1:0] KIND_NOTHING  = 2'd2;

	// Registration status.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_TOO_LONG = 2'd2;

	// One task table entry as held in the RAM.
	typedef struct packed {
		logic              ready;
		logic [TIME_W-1:0] count;
		logic [TIME_W-1:0] period;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;
		logic start_walk;
		logic do_register;
		logic step_tick;
		logic step_skip;
		logic step_take;
		logic flush;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_register;
		logic is_tick;
		logic is_dispatch;
		logic walk_done;
		logic entry_ready;
		logic pend_valid;
		logic cap_hit;
		logic out_free;
	} stat_t;

endpackage

@@ hdl/periodic_task_ready_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic task ready scheduler
// Table of periodic tasks with registration, tick and dispatch requests.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_stall and carry an action with a period and
// a start flag. Results leave on out_valid/out_stall, one per accepted
// handshake, and the final result of a request has last set. A register
// request is decoded and then places one status result in the output
// register once it is free. A tick walks the table one task entry at a
// time, each entry read from the task RAM and then updated and written
// back, so in_stall stays high for the whole walk and no result comes.
// A dispatch walks the same way and emits each ready task (at most eight) or
// one empty marker. One request is worked on at a time; in_stall is high
// from acceptance until the last result has been placed in the output
// register, so a new request can be taken while that result still waits.
// When the receiver stalls, the walk pauses at the next found task or at
// the final result. Reset empties the task table count and sets the period
// limit to 255; the table contents need no clearing since only registered
// entries are read.
// ----------------------------------------------------------------------------
module periodic_task_ready_scheduler #(
	parameter int MAX_TASKS = ptrs_pkg::MAX_TASKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration: period limit register.
	input  logic                          cfg_we,
	input  logic [ptrs_pkg::TIME_W-1:0]   cfg_wdata,
	// Request channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [ptrs_pkg::TIME_W-1:0]   period_ticks,
	input  logic                          start_ready,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    result_kind,
	output logic [1:0]                    status,
	output logic [ptrs_pkg::IDX_W-1:0]    task_index,
	output logic                          last
);

	ptrs_pkg::cmd_t  cmd;
	ptrs_pkg::stat_t st;

	// The controller only sequences; all table state lives in the datapath.
	ptrs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.st      (st),
		.cmd     (cmd)
	);

	ptrs_dp #(
		.MAX_TASKS(MAX_TASKS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.action      (action),
		.period_ticks(period_ticks),
		.start_ready (start_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.status      (status),
		.task_index  (task_index),
		.last        (last),
		.cmd         (cmd),
		.st          (st)
	);

endmodule

@@ hdl/ptrs_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/ptrs_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences registration, the tick walk and the dispatch walk.
// ----------------------------------------------------------------------------
module ptrs_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ptrs_pkg::stat_t  st,
	output ptrs_pkg::cmd_t   cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_DECODE   = 6'b000010,
		ST_REGISTER = 6'b000100,
		ST_READ     = 6'b001000,
		ST_EVAL     = 6'b010000,
		ST_FLUSH    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (st.is_register) begin
					state_d = ST_REGISTER;
				end else if (st.is_tick || st.is_dispatch) begin
					cmd.start_walk = 1'b1;
					state_d        = ST_READ;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_REGISTER: begin
				if (st.out_free) begin
					cmd.do_register = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_READ: begin
				if (!st.walk_done) begin
					state_d = ST_EVAL;
				end else if (st.is_dispatch) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EVAL: begin
				if (st.is_tick) begin
					cmd.step_tick = 1'b1;
					state_d       = ST_READ;
				end else if (!st.entry_ready) begin
					cmd.step_skip = 1'b1;
					state_d       = ST_READ;
				end else if (!st.pend_valid || st.out_free) begin
					// The previous find goes out now; this one is held until
					// we know whether it is the final result.
					cmd.step_take = 1'b1;
					state_d       = st.cap_hit ? ST_FLUSH : ST_READ;
				end
			end
			ST_FLUSH: begin
				if (st.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

@@ hdl/ptrs_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler datapath
// Task table RAM, walk index, pending dispatch result and output register.
// ----------------------------------------------------------------------------
module ptrs_dp #(
	parameter int MAX_TASKS = ptrs_pkg::MAX_TASKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ptrs_pkg::TIME_W-1:0]   cfg_wdata,
	input  logic [1:0]                    action,
	input  logic [ptrs_pkg::TIME_W-1:0]   period_ticks,
	input  logic                          start_ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    result_kind,
	output logic [1:0]                    status,
	output logic [ptrs_pkg::IDX_W-1:0]    task_index,
	output logic                          last,
	input  ptrs_pkg::cmd_t                cmd,
	output ptrs_pkg::stat_t               st
);

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int EW = $bits(ptrs_pkg::entry_t);

	logic [ptrs_pkg::TIME_W-1:0] hyper_q;
	logic [CW-1:0]               cnt_q;
	logic [1:0]                  action_q;
	logic [ptrs_pkg::TIME_W-1:0] period_q;
	logic                        start_q;
	logic [CW-1:0]               idx_q;
	logic [ptrs_pkg::NRES_W-1:0] nres_q;
	logic                        pend_v_q;
	logic [ptrs_pkg::IDX_W-1:0]  pend_idx_q;

	logic                        out_valid_q;
	logic [1:0]                  kind_q;
	logic [1:0]                  status_q;
	logic [ptrs_pkg::IDX_W-1:0]  index_q;
	logic                        last_q;

	ptrs_pkg::entry_t            rd_entry;
	ptrs_pkg::entry_t            wr_entry;
	logic [EW-1:0]               rdata;
	logic                        ram_we;
	logic [AW-1:0]               waddr;

	logic [1:0]                  reg_status;
	logic                        reg_ok;
	logic                        push;
	logic [1:0]                  push_kind;
	logic [1:0]                  push_status;
	logic [ptrs_pkg::IDX_W-1:0]  push_index;
	logic                        push_last;

	assign rd_entry = ptrs_pkg::entry_t'(rdata);

	// Registration check: a too-long period wins over a full table.
	always_comb begin
		if (period_q > hyper_q) begin
			reg_status = ptrs_pkg::STAT_TOO_LONG;
		end else if (cnt_q == CW'(MAX_TASKS)) begin
			reg_status = ptrs_pkg::STAT_FULL;
		end else begin
			reg_status = ptrs_pkg::STAT_OK;
		end
	end
	assign reg_ok = (reg_status == ptrs_pkg::STAT_OK);

	// Table write.
	always_comb begin
		ram_we   = 1'b0;
		waddr    = idx_q[AW-1:0];
		wr_entry = rd_entry;
		if (cmd.do_register) begin
			ram_we          = reg_ok;
			waddr           = cnt_q[AW-1:0];
			wr_entry.ready  = start_q;
			wr_entry.count  = ptrs_pkg::TIME_W'(1);
			wr_entry.period = period_q;
		end else if (cmd.step_tick) begin
			ram_we = 1'b1;
			if (rd_entry.count >= rd_entry.period) begin
				wr_entry.ready = 1'b1;
				wr_entry.count = ptrs_pkg::TIME_W'(1);
			end else begin
				wr_entry.count = rd_entry.count + ptrs_pkg::TIME_W'(1);
			end
		end else if (cmd.step_take) begin
			ram_we         = 1'b1;
			wr_entry.ready = 1'b0;
		end
	end

	ptrs_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_TASKS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(wr_entry),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// Result push into the output register.
	always_comb begin
		push        = 1'b0;
		push_kind   = ptrs_pkg::KIND_STATUS;
		push_status = ptrs_pkg::STAT_OK;
		push_index  = '0;
		push_last   = 1'b1;
		if (cmd.do_register) begin
			push        = 1'b1;
			push_status = reg_status;
			push_index  = reg_ok ? ptrs_pkg::IDX_W'(cnt_q) : '0;
		end else if (cmd.step_take) begin
			push       = pend_v_q;
			push_kind  = ptrs_pkg::KIND_TASK;
			push_index = pend_idx_q;
			push_last  = 1'b0;
		end else if (cmd.flush) begin
			push       = 1'b1;
			push_kind  = pend_v_q ? ptrs_pkg::KIND_TASK : ptrs_pkg::KIND_NOTHING;
			push_index = pend_v_q ? pend_idx_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyper_q     <= ptrs_pkg::HYPER_RESET;
			cnt_q       <= '0;
			idx_q       <= '0;
			nres_q      <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				hyper_q <= cfg_wdata;
			end
			if (cmd.do_register && reg_ok) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.start_walk) begin
				idx_q    <= '0;
				nres_q   <= '0;
				pend_v_q <= 1'b0;
			end else if (cmd.step_tick || cmd.step_skip) begin
				idx_q <= idx_q + CW'(1);
			end else if (cmd.step_take) begin
				idx_q    <= idx_q + CW'(1);
				nres_q   <= nres_q + ptrs_pkg::NRES_W'(1);
				pend_v_q <= 1'b1;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q <= action;
			period_q <= period_ticks;
			start_q  <= start_ready;
		end
		if (cmd.step_take) begin
			pend_idx_q <= ptrs_pkg::IDX_W'(idx_q);
		end
		if (push) begin
			kind_q   <= push_kind;
			status_q <= push_status;
			index_q  <= push_index;
			last_q   <= push_last;
		end
	end

	assign st.is_register = (action_q == ptrs_pkg::ACT_REGISTER);
	assign st.is_tick     = (action_q == ptrs_pkg::ACT_TICK);
	assign st.is_dispatch = (action_q == ptrs_pkg::ACT_DISPATCH);
	assign st.walk_done   = (idx_q == cnt_q);
	assign st.entry_ready = rd_entry.ready;
	assign st.pend_valid  = pend_v_q;
	assign st.cap_hit     = (nres_q == ptrs_pkg::NRES_W'(ptrs_pkg::MAX_RESULTS - 1));
	assign st.out_free    = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign status      = status_q;
	assign task_index  = index_q;
	assign last        = last_q;

endmodule

@@ test/tb_periodic_task_ready_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the periodic task ready scheduler
// Sends register, tick and dispatch requests with random gaps on both sides,
// predicts the task table alongside the block and compares every result.
// ----------------------------------------------------------------------------
module tb_periodic_task_ready_scheduler;

	localparam int NUM_SLOTS = ptrs_pkg::MAX_TASKS_DEF;
	// A tick walks every entry and gives no result, so after the last result
	// the block may still be busy with such a walk.
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 22;
	// The one action code the block ignores.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]                 kind;
		logic [1:0]                 stat;
		logic [ptrs_pkg::IDX_W-1:0] idx;
		logic                       last;
	} sched_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_we = 1'b0;
	logic [ptrs_pkg::TIME_W-1:0] cfg_wdata = '0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [1:0]                  action = ptrs_pkg::ACT_TICK;
	logic [ptrs_pkg::TIME_W-1:0] period_ticks = '0;
	logic                        start_ready = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [1:0]                  result_kind;
	logic [1:0]                  status;
	logic [ptrs_pkg::IDX_W-1:0]  task_index;
	logic                        last;

	always #5 clk = ~clk;

	periodic_task_ready_scheduler #(
		.MAX_TASKS(NUM_SLOTS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.period_ticks(period_ticks),
		.start_ready (start_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.status      (status),
		.task_index  (task_index),
		.last        (last)
	);

	// Our own copy of the task table and of the period limit register. It is
	// updated at the clock edge where a request is accepted, and the results
	// that request must produce are appended to pending_results in order.
	logic [ptrs_pkg::TIME_W-1:0] slot_period [NUM_SLOTS];
	logic [ptrs_pkg::TIME_W-1:0] slot_ticks  [NUM_SLOTS];
	logic                        slot_ready  [NUM_SLOTS];
	int                          slots_used = 0;
	logic [ptrs_pkg::TIME_W-1:0] hyper_limit = ptrs_pkg::HYPER_RESET;

	sched_result_t pending_results[$];
	int            mismatch_count = 0;
	int            quiet_run = 0;

	function automatic void schedule_request(input logic [1:0] act,
			input logic [ptrs_pkg::TIME_W-1:0] per, input logic sr);
		sched_result_t held;
		bit            have_held;
		int            found;
		have_held = 1'b0;
		found = 0;
		case (act)
			ptrs_pkg::ACT_REGISTER: begin
				// The period fault is checked first, so it wins over a full table.
				if (per > hyper_limit) begin
					pending_results.push_back('{ptrs_pkg::KIND_STATUS,
						ptrs_pkg::STAT_TOO_LONG, '0, 1'b1});
				end else if (slots_used >= NUM_SLOTS) begin
					pending_results.push_back('{ptrs_pkg::KIND_STATUS,
						ptrs_pkg::STAT_FULL, '0, 1'b1});
				end else begin
					slot_period[slots_used] = per;
					slot_ticks[slots_used] = 8'd1;
					slot_ready[slots_used] = sr;
					pending_results.push_back('{ptrs_pkg::KIND_STATUS, ptrs_pkg::STAT_OK,
						slots_used[ptrs_pkg::IDX_W-1:0], 1'b1});
					slots_used++;
				end
			end
			ptrs_pkg::ACT_TICK: begin
				// A task whose counter has reached its period becomes ready; a period
				// of zero therefore fires on every tick.
				for (int i = 0; i < slots_used; i++) begin
					if (slot_ticks[i] >= slot_period[i]) begin
						slot_ready[i] = 1'b1;
						slot_ticks[i] = 8'd1;
					end else begin
						slot_ticks[i] = slot_ticks[i] + 8'd1;
					end
				end
			end
			ptrs_pkg::ACT_DISPATCH: begin
				// Each result is held back one step so that the final one can be
				// marked as last before it is queued.
				for (int i = 0; i < slots_used && found < ptrs_pkg::MAX_RESULTS; i++) begin
					if (slot_ready[i]) begin
						slot_ready[i] = 1'b0;
						if (have_held)
							pending_results.push_back(held);
						held = '{ptrs_pkg::KIND_TASK, ptrs_pkg::STAT_OK,
							i[ptrs_pkg::IDX_W-1:0], 1'b0};
						have_held = 1'b1;
						found++;
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					pending_results.push_back(held);
				end else begin
					pending_results.push_back('{ptrs_pkg::KIND_NOTHING, ptrs_pkg::STAT_OK,
						'0, 1'b1});
				end
			end
			default: begin
				// The unused action leaves the table alone and returns nothing.
			end
		endcase
	endfunction

	// Gap lengths for both sides: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 24);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Sends one request and returns at the edge where it is accepted. The valid
	// stays high when the next request follows without a gap, so it is never
	// lowered and raised again in the same time step.
	task automatic send_request(input logic [1:0] act, input logic [ptrs_pkg::TIME_W-1:0] per,
			input logic sr);
		int gap;
		if (quiet_run > 0) begin
			gap = 0;
			quiet_run--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 9) == 0)
				quiet_run = $urandom_range(5, 15);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		period_ticks <= per;
		start_ready <= sr;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		schedule_request(act, per, sr);
	endtask

	// Holds off new requests until every expected result has come, then lets a
	// tick walk that gives no result finish as well.
	task automatic wait_until_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Only called while the block is idle, right after wait_until_drained.
	task automatic write_hyper(input logic [ptrs_pkg::TIME_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		hyper_limit = value;
	endtask

	// Dispatch and tick on an empty table, and the ignored action.
	task automatic test_empty_table();
		send_request(ptrs_pkg::ACT_DISPATCH, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_TICK, 8'hFF, 1'b1);
		send_request(ACT_UNUSED, 8'hA5, 1'b1);
		send_request(ptrs_pkg::ACT_DISPATCH, 8'hFF, 1'b1);
	endtask

	// Period limits at both extremes of the limit register, including period zero.
	task automatic test_registration_limits();
		wait_until_drained();
		write_hyper(8'd0);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd1, 1'b0);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd0, 1'b1);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd255, 1'b1);
		wait_until_drained();
		write_hyper(8'd255);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd255, 1'b0);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd1, 1'b1);
		wait_until_drained();
		write_hyper(8'd100);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd101, 1'b0);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd100, 1'b0);
	endtask

	// Tasks that start ready, a dispatch with nothing ready and tasks that
	// become ready through ticks.
	task automatic test_tick_and_dispatch();
		send_request(ptrs_pkg::ACT_DISPATCH, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_DISPATCH, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_TICK, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_TICK, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_DISPATCH, 8'd0, 1'b0);
		send_request(ACT_UNUSED, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_DISPATCH, 8'h5A, 1'b1);
	endtask

	// One phase of random requests under a fixed period limit. Small periods
	// dominate so that tasks fire often and dispatches return several tasks.
	task automatic run_random_phase(input logic [ptrs_pkg::TIME_W-1:0] limit, input int count);
		int                          sent;
		int                          r;
		logic [1:0]                  act;
		logic [ptrs_pkg::TIME_W-1:0] per;
		wait_until_drained();
		write_hyper(limit);
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(0, 99);
			if (r < 18)
				act = ptrs_pkg::ACT_REGISTER;
			else if (r < 58)
				act = ptrs_pkg::ACT_TICK;
			else if (r < 95)
				act = ptrs_pkg::ACT_DISPATCH;
			else
				act = ACT_UNUSED;
			r = $urandom_range(0, 99);
			if (r < 60)
				per = ptrs_pkg::TIME_W'($urandom_range(0, 5));
			else if (r < 80)
				per = ptrs_pkg::TIME_W'($urandom_range(0, limit));
			else
				per = ptrs_pkg::TIME_W'($urandom_range(0, 255));
			send_request(act, per, 1'($urandom_range(0, 1)));
			if (act != ACT_UNUSED)
				sent++;
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(ptrs_pkg::HYPER_RESET, PHASE_ITEMS);
		run_random_phase(8'd4, PHASE_ITEMS);
		run_random_phase(ptrs_pkg::TIME_W'($urandom_range(1, 254)), PHASE_ITEMS);
		run_random_phase(8'd0, PHASE_ITEMS);
	endtask

	// Fills the table, then checks both faults together, the full table alone
	// and a dispatch that returns many tasks at once.
	task automatic test_full_table();
		wait_until_drained();
		write_hyper(8'd200);
		while (slots_used < NUM_SLOTS)
			send_request(ptrs_pkg::ACT_REGISTER, ptrs_pkg::TIME_W'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)));
		send_request(ptrs_pkg::ACT_REGISTER, 8'd201, 1'b1);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd200, 1'b0);
		send_request(ptrs_pkg::ACT_TICK, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_DISPATCH, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_TICK, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_TICK, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_TICK, 8'd0, 1'b0);
		send_request(ptrs_pkg::ACT_DISPATCH, 8'd0, 1'b0);
		wait_until_drained();
		write_hyper(8'd255);
		send_request(ptrs_pkg::ACT_REGISTER, 8'd255, 1'b1);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_registration_limits();
		test_tick_and_dispatch();
		test_random_traffic();
		test_full_table();
		wait_until_drained();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// The receiver stalls at random, with occasional long stretches of none.
	initial begin : drive_out_stall
		int n;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(20, 60)) @(posedge clk);
			n = pick_gap();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
		end
	end

	// Every accepted result is matched against the oldest expected one.
	always @(posedge clk) begin : check_results
		sched_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d status %0d index %0d last %0d",
					result_kind, status, task_index, last));
			end else begin
				want = pending_results.pop_front();
				if (result_kind !== want.kind)
					report_mismatch($sformatf("result_kind %0d, expected %0d", result_kind, want.kind));
				if (status !== want.stat)
					report_mismatch($sformatf("status %0d, expected %0d", status, want.stat));
				if (task_index !== want.idx)
					report_mismatch($sformatf("task_index %0d, expected %0d", task_index, want.idx));
				if (last !== want.last)
					report_mismatch($sformatf("last %0d, expected %0d", last, want.last));
			end
		end
	end

	// Several times the slowest correct run: every request walking a full table
	// and every result held by the longest stall.
	initial begin
		#3_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
